@@ hdl/asps_pkg.sv @@
// Shared types and constants for the annulus sector point sampler.
`default_nettype none
package asps_pkg;

    localparam int ROOT_W     = 16;
    localparam int REM_W      = 19;
    localparam int TURN_W     = 16;
    localparam int RADIUS_W   = 15;
    localparam int XYZ_W      = 48;
    localparam int LANE_W     = 16;
    localparam int SIDE_W     = TURN_W + RADIUS_W;
    localparam int CELL_COUNT = ROOT_W;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_XYZ   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_XYZ  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BINORMAL_XYZ = 4'd7;

    typedef struct packed {
        logic              vld;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] rad;
        logic [SIDE_W-1:0] side;
    } asps_cell_t;

endpackage
`default_nettype wire

@@ hdl/annulus_sector_point_sampler.sv @@
// Throughput: one item per cycle; the whole pipeline advances together when the
// output register is empty or taken, so a stalled output stops the 16-cell root chain.
// Reset: synchronous active-low aresetn clears all stage valid bits and loads the
// register defaults (surface mode, unit outer radius, full turn, x/y unit vectors).
`default_nettype none
module annulus_sector_point_sampler #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [15:0]                        s_angle_fraction,
    input  wire logic [15:0]                        s_radius_or_pick_fraction,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [COORD_WIDTH-1:0]           m_point_x,
    output logic signed [COORD_WIDTH-1:0]           m_point_y,
    output logic signed [COORD_WIDTH-1:0]           m_point_z,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [asps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [asps_pkg::XYZ_W-1:0]         cfg_data
);
    import asps_pkg::*;

    localparam int PROD_W = ANGLE_WIDTH + 18;
    localparam int SUM_W  = 50;
    localparam int PNT_W  = 40;
    localparam logic signed [PNT_W-1:0] LIM_HI = PNT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [PNT_W-1:0] LIM_LO = PNT_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    logic                    edge_mode_reg;
    logic [RADIUS_W-1:0]     inner_reg, outer_reg;
    logic [ANGLE_WIDTH-1:0]  min_angle_reg, max_angle_reg;
    logic [XYZ_W-1:0]        center_reg, tangent_reg, binormal_reg;

    logic en;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_mode_reg <= 1'b0;
            inner_reg     <= '0;
            outer_reg     <= RADIUS_W'(256);
            min_angle_reg <= '0;
            max_angle_reg <= '1;
            center_reg    <= '0;
            tangent_reg   <= XYZ_W'(16384);
            binormal_reg  <= XYZ_W'(48'h0000_4000_0000);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_EDGE_MODE:    edge_mode_reg <= cfg_data[0];
                CFG_INNER_RADIUS: inner_reg     <= cfg_data[RADIUS_W-1:0];
                CFG_OUTER_RADIUS: outer_reg     <= cfg_data[RADIUS_W-1:0];
                CFG_MIN_ANGLE:    min_angle_reg <= cfg_data[ANGLE_WIDTH-1:0];
                CFG_MAX_ANGLE:    max_angle_reg <= cfg_data[ANGLE_WIDTH-1:0];
                CFG_CENTER_XYZ:   center_reg    <= cfg_data;
                CFG_TANGENT_XYZ:  tangent_reg   <= cfg_data;
                CFG_BINORMAL_XYZ: binormal_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: span product, ring pick product
    logic signed [ANGLE_WIDTH:0] span;
    logic signed [PROD_W-1:0]    prod_next, prod_reg;
    logic [31:0]                 pick_next, pick_reg;
    logic [15:0]                 u2_1_reg, u2_2_reg;
    logic                        v1_reg, v2_reg;
    logic [ANGLE_WIDTH-1:0]      angle;
    logic [TURN_W-1:0]           t_next, t2_reg;
    logic [RADIUS_W-1:0]         redge_next, redge2_reg;

    always_comb begin
        span      = $signed({1'b0, max_angle_reg}) - $signed({1'b0, min_angle_reg});
        prod_next = PROD_W'($signed({1'b0, s_angle_fraction}) * span);
        pick_next = s_radius_or_pick_fraction * 32'({1'b0, inner_reg} + {1'b0, outer_reg});
        angle     = min_angle_reg + prod_reg[16 +: ANGLE_WIDTH];
        t_next    = TURN_W'((40'(angle) << 16) >> ANGLE_WIDTH);
        redge_next = ((span != '0) && (pick_reg < {1'b0, inner_reg, 16'h0000}))
                   ? inner_reg : outer_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            prod_reg   <= prod_next;
            pick_reg   <= pick_next;
            u2_1_reg   <= s_radius_or_pick_fraction;
            t2_reg     <= t_next;
            redge2_reg <= redge_next;
            u2_2_reg   <= u2_1_reg;
        end
    end

    // root chain
    asps_cell_t chain [CELL_COUNT+1];
    assign chain[0].vld  = v2_reg;
    assign chain[0].rem  = '0;
    assign chain[0].root = '0;
    assign chain[0].rad  = u2_2_reg;
    assign chain[0].side = {t2_reg, redge2_reg};

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        asps_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    asps_cell_t    tail;
    logic [TURN_W-1:0] tail_t, tail_tc;
    assign tail    = chain[CELL_COUNT];
    assign tail_t  = tail.side[SIDE_W-1 -: TURN_W];
    assign tail_tc = tail_t + TURN_W'(16384);

    logic signed [LANE_W-1:0] sn, cs;
    asps_sine u_sin (.aclk(aclk), .en(en), .turn(tail_t),  .sine(sn));
    asps_sine u_cos (.aclk(aclk), .en(en), .turn(tail_tc), .sine(cs));

    // radius
    logic signed [16:0]  rdiff;
    logic signed [33:0]  dprod_next, dprod_reg;
    logic [RADIUS_W-1:0] redge_r1_reg, r_next, r2_reg, r3_reg, r4_reg;
    logic                vr1_reg, vr2_reg, vr3_reg, vr4_reg;

    always_comb begin
        rdiff      = $signed({2'b00, outer_reg}) - $signed({2'b00, inner_reg});
        dprod_next = $signed({1'b0, tail.root}) * rdiff;
        r_next     = edge_mode_reg ? redge_r1_reg
                                   : RADIUS_W'(inner_reg + dprod_reg[16 +: RADIUS_W]);
    end

    // products and output
    logic signed [31:0] rs_next, rc_next, rs_reg, rc_reg;
    logic signed [47:0] pt_reg [3];
    logic signed [47:0] pb_reg [3];
    logic               vm1_reg, vm2_reg, out_vld_reg;
    logic signed [SUM_W-1:0] sum [3];
    logic signed [PNT_W-1:0] pnt [3];
    logic signed [COORD_WIDTH-1:0] pnt_sat [3];
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg, pz_reg;

    assign rs_next = 32'($signed({1'b0, r4_reg}) * sn);
    assign rc_next = 32'($signed({1'b0, r4_reg}) * cs);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = SUM_W'(pt_reg[k]) + SUM_W'(pb_reg[k]) + SUM_W'(64'sd1 <<< 27);
            pnt[k] = PNT_W'(sum[k] >>> 28)
                   + PNT_W'($signed(center_reg[16*k +: LANE_W]));
            if (pnt[k] > LIM_HI) begin
                pnt_sat[k] = COORD_WIDTH'(LIM_HI);
            end else if (pnt[k] < LIM_LO) begin
                pnt_sat[k] = COORD_WIDTH'(LIM_LO);
            end else begin
                pnt_sat[k] = COORD_WIDTH'(pnt[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr1_reg     <= 1'b0;
            vr2_reg     <= 1'b0;
            vr3_reg     <= 1'b0;
            vr4_reg     <= 1'b0;
            vm1_reg     <= 1'b0;
            vm2_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vr1_reg     <= tail.vld;
            vr2_reg     <= vr1_reg;
            vr3_reg     <= vr2_reg;
            vr4_reg     <= vr3_reg;
            vm1_reg     <= vr4_reg;
            vm2_reg     <= vm1_reg;
            out_vld_reg <= vm2_reg;
        end
        if (en) begin
            dprod_reg    <= dprod_next;
            redge_r1_reg <= tail.side[RADIUS_W-1:0];
            r2_reg       <= r_next;
            r3_reg       <= r2_reg;
            r4_reg       <= r3_reg;
            rs_reg       <= rs_next;
            rc_reg       <= rc_next;
            for (int k = 0; k < 3; k++) begin
                pt_reg[k] <= 48'(rs_reg * $signed(tangent_reg[16*k +: LANE_W]));
                pb_reg[k] <= 48'(rc_reg * $signed(binormal_reg[16*k +: LANE_W]));
            end
            px_reg <= pnt_sat[0];
            py_reg <= pnt_sat[1];
            pz_reg <= pnt_sat[2];
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_point_x = px_reg;
    assign m_point_y = py_reg;
    assign m_point_z = pz_reg;

    a_cfg_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == CFG_EDGE_MODE |=> edge_mode_reg == $past(cfg_data[0]))
        else $error("edge mode write lost");

    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vr4_reg |-> (sn <= 16'sd16384 && sn >= -16'sd16384
                     && cs <= 16'sd16384 && cs >= -16'sd16384))
        else $error("sine out of range");

    a_radius_span: assert property (@(posedge aclk) disable iff (!aresetn)
        vr2_reg && !edge_mode_reg |->
            ((r2_reg >= inner_reg && r2_reg <= outer_reg)
             || (r2_reg <= inner_reg && r2_reg >= outer_reg)))
        else $error("surface radius outside annulus");
endmodule
`default_nettype wire

@@ hdl/asps_sqrt_cell.sv @@
// One cell of the square-root chain: resolves one root bit per cell.
`default_nettype none
module asps_sqrt_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  asps_pkg::asps_cell_t    cell_in,
    output asps_pkg::asps_cell_t    cell_out
);
    import asps_pkg::*;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;
    asps_cell_t       cell_next;
    asps_cell_t       cell_reg;

    always_comb begin
        rem_sh = {cell_in.rem[REM_W-3:0], cell_in.rad[ROOT_W-1 -: 2]};
        trial  = {1'b0, cell_in.root, 2'b01};
        fits   = (rem_sh >= trial);
        cell_next.vld  = cell_in.vld;
        cell_next.rem  = fits ? (rem_sh - trial) : rem_sh;
        cell_next.root = {cell_in.root[ROOT_W-2:0], fits};
        cell_next.rad  = {cell_in.rad[ROOT_W-3:0], 2'b00};
        cell_next.side = cell_in.side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg.vld <= cell_next.vld;
        end
        if (en) begin
            cell_reg.rem  <= cell_next.rem;
            cell_reg.root <= cell_next.root;
            cell_reg.rad  <= cell_next.rad;
            cell_reg.side <= cell_next.side;
        end
    end

    assign cell_out = cell_reg;
endmodule
`default_nettype wire

@@ hdl/asps_sine.sv @@
// Four-stage polynomial sine of a 16-bit turn angle, Q1.14 result.
`default_nettype none
module asps_sine (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [asps_pkg::TURN_W-1:0]       turn,
    output logic signed [asps_pkg::LANE_W-1:0]     sine
);
    import asps_pkg::*;

    logic [14:0] z_next;
    logic [29:0] zz;
    logic [14:0] z1_reg, z2_1_reg, z2_2_reg;
    logic [14:0] z_2_reg, z_3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [25:0] p1160;
    logic [13:0] i_next, i_reg;
    logic [28:0] pzi;
    logic [14:0] m_next, m_reg;
    logic [29:0] pzm;
    logic signed [LANE_W-1:0] sine_next, sine_reg;

    always_comb begin
        z_next    = turn[14] ? (15'd16384 - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
        zz        = z_next * z_next;
        p1160     = z2_1_reg * 11'd1160;
        i_next    = 14'(14'd10512 - 14'(p1160 >> 14));
        pzi       = z2_2_reg * i_reg;
        m_next    = 15'(15'd25736 - 15'(pzi >> 14));
        pzm       = z_3_reg * m_reg;
        sine_next = neg3_reg ? -$signed({1'b0, pzm[28:14]}) : $signed({1'b0, pzm[28:14]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg   <= z_next;
            z2_1_reg <= zz[28:14];
            neg1_reg <= turn[15];
            i_reg    <= i_next;
            z2_2_reg <= z2_1_reg;
            z_2_reg  <= z1_reg;
            neg2_reg <= neg1_reg;
            m_reg    <= m_next;
            z_3_reg  <= z_2_reg;
            neg3_reg <= neg2_reg;
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;
endmodule
`default_nettype wire

@@ bench/asps_checker.sv @@
// Checker for the annulus sector point sampler: watches all channels, predicts points, compares.
module asps_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [15:0] s_angle_fraction,
    input  wire logic [15:0] s_radius_or_pick_fraction,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_point_x,
    input  wire logic [15:0] m_point_y,
    input  wire logic [15:0] m_point_z,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    output int               errors,
    output int               points_waiting,
    output int               points_compared
);
    timeunit 1ns;
    timeprecision 1ps;
    import asps_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } point_t;

    logic        edge_mode;
    logic [14:0] inner_radius;
    logic [14:0] outer_radius;
    logic [15:0] min_angle;
    logic [15:0] max_angle;
    logic [47:0] center_xyz;
    logic [47:0] tangent_xyz;
    logic [47:0] binormal_xyz;

    point_t expected_points[$];

    function automatic longint lane(logic [47:0] r, int k);
        logic [15:0] f;
        f = r[16*k +: 16];
        return longint'($signed(f));
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 30;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint turn_sine(int unsigned t);
        int unsigned q;
        longint f, z, z2, i, m, s;
        q = (t >> 14) & 3;
        f = t & 16'h3FFF;
        z = q[0] ? 16384 - f : f;
        z2 = (z * z) >>> 14;
        i = 10512 - ((z2 * 1160) >>> 14);
        m = 25736 - ((z2 * i) >>> 14);
        s = (z * m) >>> 14;
        return (q >= 2) ? -s : s;
    endfunction

    function automatic point_t predict_point(logic [15:0] u1f, logic [15:0] u2f);
        longint u1, u2, inner, outer, span, theta, sn, cs, r, sum, p;
        logic [15:0] t;
        logic [15:0] c [3];
        point_t pt;
        u1 = u1f;
        u2 = u2f;
        inner = inner_radius;
        outer = outer_radius;
        span = longint'(max_angle) - longint'(min_angle);
        theta = longint'(min_angle) + ((u1 * span) >>> 16);
        t = theta[15:0];
        sn = turn_sine(t);
        cs = turn_sine((t + 16384) & 16'hFFFF);
        if (edge_mode) begin
            r = (span != 0 && u2 * (inner + outer) < inner * 65536) ? inner : outer;
        end else begin
            r = inner + ((isqrt(longint'(u2) << 16) * (outer - inner)) >>> 16);
        end
        for (int k = 0; k < 3; k++) begin
            sum = r * sn * lane(tangent_xyz, k) + r * cs * lane(binormal_xyz, k);
            p = lane(center_xyz, k) + ((sum + (64'sd1 <<< 27)) >>> 28);
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            c[k] = p[15:0];
        end
        pt.x = c[0];
        pt.y = c[1];
        pt.z = c[2];
        return pt;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        errors++;
    endtask

    assign points_waiting = expected_points.size();

    initial begin
        errors = 0;
        points_compared = 0;
    end

    always @(posedge aclk) begin
        point_t want;
        if (!aresetn) begin
            edge_mode    <= 1'b0;
            inner_radius <= 15'd0;
            outer_radius <= 15'd256;
            min_angle    <= 16'd0;
            max_angle    <= 16'hFFFF;
            center_xyz   <= 48'd0;
            tangent_xyz  <= 48'd16384;
            binormal_xyz <= 48'd1073741824;
            expected_points.delete();
        end else begin
            if (s_valid && s_ready)
                expected_points = {expected_points,
                                   predict_point(s_angle_fraction,
                                                 s_radius_or_pick_fraction)};
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $display("unexpected point at %0t", $realtime);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    points_compared++;
                    if (m_point_x !== want.x) report_mismatch("x", m_point_x, want.x);
                    if (m_point_y !== want.y) report_mismatch("y", m_point_y, want.y);
                    if (m_point_z !== want.z) report_mismatch("z", m_point_z, want.z);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EDGE_MODE:    edge_mode    <= cfg_data[0];
                    CFG_INNER_RADIUS: inner_radius <= cfg_data[14:0];
                    CFG_OUTER_RADIUS: outer_radius <= cfg_data[14:0];
                    CFG_MIN_ANGLE:    min_angle    <= cfg_data[15:0];
                    CFG_MAX_ANGLE:    max_angle    <= cfg_data[15:0];
                    CFG_CENTER_XYZ:   center_xyz   <= cfg_data;
                    CFG_TANGENT_XYZ:  tangent_xyz  <= cfg_data;
                    CFG_BINORMAL_XYZ: binormal_xyz <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ bench/annulus_sector_point_sampler_test.sv @@
// Top of the point sampler testbench: clock, reset, stimulus, stalls and verdict.
module annulus_sector_point_sampler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import asps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_angle_fraction = '0;
    logic [15:0] s_radius_or_pick_fraction = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_point_x, m_point_y, m_point_z;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [XYZ_W-1:0]     cfg_data = '0;

    int errors, points_waiting, points_compared;
    int items_sent = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    int stall_left = 0;

    always #5 aclk = ~aclk;

    annulus_sector_point_sampler dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_angle_fraction,
        .s_radius_or_pick_fraction, .m_valid, .m_ready, .m_point_x, .m_point_y,
        .m_point_z, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    asps_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_angle_fraction,
        .s_radius_or_pick_fraction, .m_valid, .m_ready, .m_point_x, .m_point_y,
        .m_point_z, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .points_waiting, .points_compared
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 60) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d points outstanding", points_waiting);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [15:0] u1, logic [15:0] u2);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_angle_fraction <= u1;
        s_radius_or_pick_fraction <= u2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // hold the sender until every point has come back, then let the pipe empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (points_waiting != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [XYZ_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [XYZ_W-1:0] rand48();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [XYZ_W-1:0] rand_field(int w);
        logic [XYZ_W-1:0] v;
        int roll;
        roll = $urandom_range(9);
        v = rand48();
        if (roll == 0) v = '0;
        else if (roll == 1) v = '1;
        else if (roll < 5) v = v & 48'h3FF;
        return v & ((48'd1 << w) - 48'd1);
    endfunction

    function automatic logic [XYZ_W-1:0] rand_vector();
        int roll;
        roll = $urandom_range(3);
        if (roll == 0) return 48'h0000_0000_4000 << (16 * $urandom_range(2));
        if (roll == 1) return 48'h0000_0000_C000 << (16 * $urandom_range(2));
        return rand48();
    endfunction

    task automatic random_setting();
        logic [XYZ_W-1:0] a;
        write_reg(CFG_EDGE_MODE, rand48());
        write_reg(CFG_INNER_RADIUS, rand_field(15));
        write_reg(CFG_OUTER_RADIUS, rand_field(15));
        a = rand48();
        write_reg(CFG_MIN_ANGLE, a);
        write_reg(CFG_MAX_ANGLE, ($urandom_range(5) == 0) ? a : rand48());
        write_reg(CFG_CENTER_XYZ, ($urandom_range(2) == 0) ? 48'd0 : rand48());
        write_reg(CFG_TANGENT_XYZ, rand_vector());
        write_reg(CFG_BINORMAL_XYZ, rand_vector());
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(15, 8)), rand48());
        settings_used++;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: full turn, unit outer radius
        no_idle = 1'b1;
        send_item(16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'hFFFF);
        send_item(16'h8000, 16'h0001);
        send_item(16'h4000, 16'hFFFF);
        no_idle = 1'b0;
        drain();

        // edge rings, inner at half of outer
        write_reg(CFG_EDGE_MODE, 48'd1);
        write_reg(CFG_INNER_RADIUS, 48'd128);
        write_reg(CFG_OUTER_RADIUS, 48'd256);
        send_item(16'h1234, 16'h0000);
        send_item(16'h0000, 16'hFFFF);
        send_item(16'h7000, 16'd21845);
        send_item(16'h7000, 16'd21846);
        drain();

        // zero span and then zero radii both fall to the outer ring
        write_reg(CFG_MIN_ANGLE, 48'd1000);
        write_reg(CFG_MAX_ANGLE, 48'd1000);
        send_item(16'hFFFF, 16'h0000);
        send_item(16'h0000, 16'h0000);
        drain();
        write_reg(CFG_MAX_ANGLE, 48'd30000);
        write_reg(CFG_INNER_RADIUS, 48'd0);
        write_reg(CFG_OUTER_RADIUS, 48'd0);
        send_item(16'h5555, 16'h0000);
        send_item(16'hAAAA, 16'hFFFF);
        drain();

        // surface mode, reversed span, outer below inner
        write_reg(CFG_EDGE_MODE, 48'd0);
        write_reg(CFG_MIN_ANGLE, 48'd60000);
        write_reg(CFG_MAX_ANGLE, 48'd100);
        write_reg(CFG_INNER_RADIUS, 48'h7FFF);
        write_reg(CFG_OUTER_RADIUS, 48'h8000_0000);
        send_item(16'hFFFF, 16'h0000);
        send_item(16'h3000, 16'hFFFF);
        send_item(16'hC000, 16'h8000);
        drain();

        // coordinates pushed past both rails; stray index must be ignored
        write_reg(CFG_CENTER_XYZ, 48'h0000_8000_7FFF);
        write_reg(CFG_TANGENT_XYZ, 48'h4000_C000_4000);
        write_reg(CFG_BINORMAL_XYZ, 48'hC000_4000_4000);
        write_reg(CFG_IDX_W'(15), '1);
        send_item(16'h0000, 16'hFFFF);
        send_item(16'h2000, 16'hFFFF);
        send_item(16'h6000, 16'hFFFF);
        send_item(16'hE000, 16'h0000);
        drain();
        settings_used += 6;

        for (int phase = 0; phase < 20; phase++) begin
            random_setting();
            no_idle = (phase % 5 == 4);
            for (int n = 0; n < 100; n++)
                send_item(16'($urandom()), 16'($urandom()));
            no_idle = 1'b0;
            drain();
        end

        $display("%0d items sent across %0d register settings, %0d points compared",
                 items_sent, settings_used, points_compared);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ annulus_sector_point_sampler.f @@
hdl/asps_pkg.sv
hdl/asps_sqrt_cell.sv
hdl/asps_sine.sv
hdl/annulus_sector_point_sampler.sv
bench/asps_checker.sv
bench/annulus_sector_point_sampler_test.sv
